FILE: rtl/int_to_radix_string_core_assert.svh
// Assertion macros for the RTL of the integer to text converter; itrs_back includes them.
`ifndef INT_TO_RADIX_STRING_CORE_ASSERT_SVH
`define INT_TO_RADIX_STRING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ITRS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ITRS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ITRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/itrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itrs_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 5;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 7;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(16);

   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

   // The divider retires this many quotient bits per cycle.
   localparam int CHUNK_BITS = 8;
   localparam int PAD_WIDTH  = ((VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
   localparam int DIV_STEPS  = PAD_WIDTH / CHUNK_BITS;
   localparam int STEP_WIDTH = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // One digit store entry per possible digit; base two gives the most digits.
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int ADDR_WIDTH  = $clog2(DIGIT_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [RADIX_WIDTH-1:0] base;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_FETCH,
      ST_EMIT
   } back_state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      unique case (d)
         4'h0: c = CHAR_WIDTH'(48);
         4'h1: c = CHAR_WIDTH'(49);
         4'h2: c = CHAR_WIDTH'(50);
         4'h3: c = CHAR_WIDTH'(51);
         4'h4: c = CHAR_WIDTH'(52);
         4'h5: c = CHAR_WIDTH'(53);
         4'h6: c = CHAR_WIDTH'(54);
         4'h7: c = CHAR_WIDTH'(55);
         4'h8: c = CHAR_WIDTH'(56);
         4'h9: c = CHAR_WIDTH'(57);
         4'hA: c = CHAR_WIDTH'(65);
         4'hB: c = CHAR_WIDTH'(66);
         4'hC: c = CHAR_WIDTH'(67);
         4'hD: c = CHAR_WIDTH'(68);
         4'hE: c = CHAR_WIDTH'(69);
         default: c = CHAR_WIDTH'(70);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/itrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module itrs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/itrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itrs_front
   import itrs_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic        [RADIX_WIDTH-1:0] csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire logic                          queue_full,
   output logic                               push,
   output entry_type                          push_entry
);

   logic [RADIX_WIDTH-1:0] radix_ff;
   logic [RADIX_WIDTH-1:0] radix_in;
   logic [RADIX_WIDTH-1:0] base;
   logic [VALUE_WIDTH-1:0] raw;
   logic                   negative;

   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en) begin
         radix_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Out-of-range bases saturate to the nearest legal one.
   always_comb begin
      base = radix_ff;
      if (radix_ff < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base = RADIX_MAX;
      end
   end

   // The negated most negative value is exact as an unsigned magnitude.
   assign raw      = req_value;
   assign negative = raw[VALUE_WIDTH-1];

   assign req_stall            = queue_full;
   assign push                 = req_valid && !queue_full;
   assign push_entry.negative  = negative;
   assign push_entry.magnitude = negative ? (~raw + VALUE_WIDTH'(1)) : raw;
   assign push_entry.base      = base;

endmodule

`default_nettype wire

FILE: rtl/itrs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module itrs_queue
   import itrs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           pop_valid,
   output entry_type      pop_entry
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff;
   logic [QPTR_WIDTH-1:0] wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff;
   logic [QPTR_WIDTH-1:0] rd_ptr_in;
   logic [QCNT_WIDTH-1:0] fill_ff;
   logic [QCNT_WIDTH-1:0] fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (fill_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/itrs_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "int_to_radix_string_core_assert.svh"

module itrs_back
   import itrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  entry_valid,
   input  wire entry_type             entry,
   output logic                       entry_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [CHAR_WIDTH-1:0] rsp_char_code,
   output logic                       rsp_last
);

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [PAD_WIDTH-1:0]   quot_ff;
   logic [PAD_WIDTH-1:0]   quot_in;
   logic [RADIX_WIDTH-1:0] rem_ff;
   logic [RADIX_WIDTH-1:0] rem_in;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [STEP_WIDTH-1:0]  step_in;
   logic [ADDR_WIDTH-1:0]  count_ff;
   logic [ADDR_WIDTH-1:0]  count_in;
   logic [ADDR_WIDTH-1:0]  idx_ff;
   logic [ADDR_WIDTH-1:0]  idx_in;
   logic                   neg_ff;
   logic                   neg_in;
   logic [RADIX_WIDTH-1:0] base_ff;
   logic [RADIX_WIDTH-1:0] base_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff;
   logic [CHAR_WIDTH-1:0]  rsp_char_in;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;

   logic [PAD_WIDTH-1:0]   div_q;
   logic [RADIX_WIDTH-1:0] div_r;
   logic                   last_step;
   logic                   out_free;
   logic                   load;
   logic [CHAR_WIDTH-1:0]  load_char;
   logic                   load_last;

   logic                   ram_we;
   logic                   ram_re;
   logic [ADDR_WIDTH-1:0]  ram_raddr;
   logic [DIGIT_WIDTH-1:0] ram_rdata;

   itrs_ram #(
      .WIDTH (DIGIT_WIDTH),
      .DEPTH (DIGIT_DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff),
      .wr_data (div_r[DIGIT_WIDTH-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Restoring division, one chunk of dividend bits per cycle. The remainder
   // stays below the base, so its top bit is free before each shift.
   always_comb begin
      div_r = rem_ff;
      div_q = quot_ff;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         div_r = {div_r[RADIX_WIDTH-2:0], div_q[PAD_WIDTH-1]};
         div_q = {div_q[PAD_WIDTH-2:0], 1'b0};
         if (div_r >= base_ff) begin
            div_r    = div_r - base_ff;
            div_q[0] = 1'b1;
         end
      end
   end

   assign last_step = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (last_step && (div_q == '0)) begin
               state_in = neg_ff ? ST_SIGN : ST_FETCH;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && (idx_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      entry_pop = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = idx_ff;
      load      = 1'b0;
      load_char = ASCII_MINUS;
      load_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               entry_pop                     = 1'b1;
               quot_in                       = '0;
               quot_in[VALUE_WIDTH-1:0]      = entry.magnitude;
               rem_in                        = '0;
               step_in                       = '0;
               count_in                      = '0;
               neg_in                        = entry.negative;
               base_in                       = entry.base;
            end
         end
         ST_DIV: begin
            quot_in = div_q;
            rem_in  = div_r;
            step_in = step_ff + STEP_WIDTH'(1);
            if (last_step) begin
               // One digit is done; the quotient becomes the next dividend.
               ram_we   = 1'b1;
               count_in = count_ff + ADDR_WIDTH'(1);
               idx_in   = count_ff;
               step_in  = '0;
               rem_in   = '0;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               load      = 1'b1;
               load_char = ASCII_MINUS;
               load_last = 1'b0;
            end
         end
         ST_FETCH: begin
            ram_re = 1'b1;
         end
         ST_EMIT: begin
            if (out_free) begin
               load      = 1'b1;
               load_char = digit_char(ram_rdata);
               load_last = (idx_ff == '0);
               if (idx_ff != '0) begin
                  // Prefetch the next lower digit so one word leaves per cycle while the output is not stalled.
                  idx_in    = idx_ff - ADDR_WIDTH'(1);
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - ADDR_WIDTH'(1);
               end
            end
         end
         default: begin
            entry_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = load_char;
         rsp_last_in  = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   `ITRS_ASSERT_IMPLIES(a_pop_only_idle, clock, reset, entry_pop,
      (state_ff == ST_IDLE) && entry_valid)
   `ITRS_ASSERT_IMPLIES(a_rem_below_base, clock, reset, state_ff == ST_DIV, rem_ff < base_ff)
   `ITRS_ASSERT_IMPLIES(a_digit_below_base, clock, reset, state_ff == ST_EMIT,
      {1'b0, ram_rdata} < base_ff)
   `ITRS_ASSERT_NEXT(a_last_ends_text, clock, reset, load && load_last,
      (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)

endmodule

`default_nettype wire

FILE: rtl/int_to_radix_string_core.sv
// An accepted word is registered in the queue before the back end takes it; each
// digit is divided out at 8 quotient bits per cycle over a 32-bit dividend, and the
// text leaves one word per cycle while rsp_stall does not hold the output. A two-entry
// queue lets the next value be taken while one is converted. Reset is synchronous
// and active high: it sets the base to ten, empties the queue and returns the back
// end to idle; the digit store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module int_to_radix_string_core
   import itrs_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic        [RADIX_WIDTH-1:0] csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic             [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                               rsp_last
);

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   itrs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   itrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   itrs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (pop_valid),
      .entry         (pop_entry),
      .entry_pop     (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
